/* hw/rtl/mrim_pkg.sv */
package mrim_pkg;

    localparam int MAX_REGISTERS_DEF = 125;
    localparam int FRAME_LEN = 8;
    localparam int FRAME_CNT_W = $clog2(FRAME_LEN + 1);

    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
    localparam logic [7:0] FUNC_READ_INPUT = 8'h04;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_RX    = 2'd1,
        OP_TICK  = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        KIND_TX      = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_STATUS  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_SHORT = 2'd1,
        ST_CRC   = 2'd2
    } t_status;

    typedef enum logic {
        PH_IDLE = 1'b0,
        PH_WAIT = 1'b1
    } t_phase;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data;
        t_status     status;
        logic        last;
    } t_result;

    // one registered input beat; crc_part covers address, function code and
    // start register high byte
    typedef struct packed {
        t_op         op;
        logic [7:0]  addr;
        logic [15:0] start_reg;
        logic [6:0]  count;
        logic [7:0]  rx;
        logic [15:0] crc_part;
    } t_item;

    typedef logic [255:0][15:0] t_crc_tab;

    function automatic t_crc_tab gen_crc_table();
        t_crc_tab tab;
        logic [15:0] c;
        for (int i = 0; i < 256; i++) begin
            c = 16'(i);
            for (int b = 0; b < 8; b++) begin
                c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
            end
            tab[i] = c;
        end
        return tab;
    endfunction

    localparam t_crc_tab CRC_TABLE = gen_crc_table();

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [7:0] idx;
        idx = crc[7:0] ^ b;
        return {8'h00, crc[15:8]} ^ CRC_TABLE[idx];
    endfunction

endpackage

/* hw/rtl/mrim_req_build.sv */
module mrim_req_build #(
    parameter int MAX_REGISTERS = mrim_pkg::MAX_REGISTERS_DEF
) (
    input  mrim_pkg::t_item                          i_item,
    output logic [6:0]                               o_count_sat,
    output mrim_pkg::t_result [mrim_pkg::FRAME_LEN-1:0] o_frame
);
    import mrim_pkg::*;

    localparam logic [6:0] MAX_CNT = 7'(MAX_REGISTERS);

    logic [6:0]  cnt_sat;
    logic [15:0] crc_a;
    logic [15:0] crc_b;
    logic [15:0] crc;
    logic [FRAME_LEN-1:0][7:0] bytes;

    always_comb begin
        cnt_sat = (i_item.count > MAX_CNT) ? MAX_CNT : i_item.count;
        // finish the CRC over start low, count high (always zero), count low
        crc_a = crc_byte(i_item.crc_part, i_item.start_reg[7:0]);
        crc_b = crc_byte(crc_a, 8'h00);
        crc   = crc_byte(crc_b, {1'b0, cnt_sat});

        bytes[0] = i_item.addr;
        bytes[1] = FUNC_READ_INPUT;
        bytes[2] = i_item.start_reg[15:8];
        bytes[3] = i_item.start_reg[7:0];
        bytes[4] = 8'h00;
        bytes[5] = {1'b0, cnt_sat};
        bytes[6] = crc[7:0];
        bytes[7] = crc[15:8];

        for (int k = 0; k < FRAME_LEN; k++) begin
            o_frame[k].kind   = KIND_TX;
            o_frame[k].data   = bytes[k];
            o_frame[k].status = ST_OK;
            o_frame[k].last   = (k == FRAME_LEN - 1);
        end
    end

    assign o_count_sat = cnt_sat;

endmodule

/* hw/rtl/mrim_resp.sv */
module mrim_resp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [15:0]       i_timeout,
    input  logic              i_go,
    input  mrim_pkg::t_item   i_item,
    input  logic [6:0]        i_count_sat,
    output logic              o_res_valid,
    output mrim_pkg::t_result o_res
);
    import mrim_pkg::*;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_exp, n_exp;
    logic [7:0]  r_rcvd, n_rcvd;
    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_held, n_held;
    logic [15:0] r_to, n_to;

    logic [8:0]  idx_p2;
    logic [8:0]  idx_p3;
    logic [8:0]  exp9;
    logic [15:0] to_inc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_exp   <= '0;
            r_rcvd  <= '0;
            r_crc   <= CRC_INIT;
            r_held  <= '0;
            r_to    <= '0;
        end else if (i_go) begin
            r_phase <= n_phase;
            r_exp   <= n_exp;
            r_rcvd  <= n_rcvd;
            r_crc   <= n_crc;
            r_held  <= n_held;
            r_to    <= n_to;
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_exp   = r_exp;
        n_rcvd  = r_rcvd;
        n_crc   = r_crc;
        n_held  = r_held;
        n_to    = r_to;
        o_res_valid = 1'b0;
        o_res.kind   = KIND_PAYLOAD;
        o_res.data   = i_item.rx;
        o_res.status = ST_OK;
        o_res.last   = 1'b0;

        idx_p2 = {1'b0, r_rcvd} + 9'd2;
        idx_p3 = {1'b0, r_rcvd} + 9'd3;
        exp9   = {1'b0, r_exp};
        to_inc = r_to + 16'd1;

        unique case (i_item.op)
            OP_START: begin
                n_phase = PH_WAIT;
                n_exp   = 8'd5 + {i_count_sat, 1'b0};
                n_rcvd  = '0;
                n_crc   = CRC_INIT;
                n_held  = '0;
                n_to    = '0;
            end
            OP_RX: begin
                if (r_phase == PH_WAIT) begin
                    n_rcvd = r_rcvd + 8'd1;
                    if (idx_p2 < exp9) begin
                        n_crc = crc_byte(r_crc, i_item.rx);
                        if (r_rcvd >= 8'd3) begin
                            o_res_valid = 1'b1;
                            o_res.last  = (idx_p3 == exp9);
                        end
                    end else if (idx_p2 == exp9) begin
                        n_held = i_item.rx;
                    end else begin
                        // second CRC byte closes the response
                        o_res_valid  = 1'b1;
                        o_res.kind   = KIND_STATUS;
                        o_res.data   = 8'h00;
                        o_res.status = ({i_item.rx, r_held} == r_crc) ? ST_OK : ST_CRC;
                        o_res.last   = 1'b1;
                        n_phase      = PH_IDLE;
                    end
                end
            end
            OP_TICK: begin
                if (r_phase == PH_WAIT) begin
                    n_to = to_inc;
                    if (to_inc >= i_timeout || to_inc == 16'd0) begin
                        o_res_valid  = 1'b1;
                        o_res.kind   = KIND_STATUS;
                        o_res.data   = 8'h00;
                        o_res.status = ST_SHORT;
                        o_res.last   = 1'b1;
                        n_phase      = PH_IDLE;
                    end
                end
            end
            default: begin
            end
        endcase
    end

endmodule

/* hw/rtl/mrim_out_ser.sv */
module mrim_out_ser (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_load,
    input  logic [mrim_pkg::FRAME_CNT_W-1:0]         i_cnt,
    input  mrim_pkg::t_result [mrim_pkg::FRAME_LEN-1:0] i_ents,
    output logic                                     o_free,
    output logic                                     o_valid,
    input  logic                                     i_ready,
    output mrim_pkg::t_result                        o_res
);
    import mrim_pkg::*;

    t_result [FRAME_LEN-1:0] r_buf;
    logic [FRAME_CNT_W-1:0]  r_cnt;
    logic                    pop;

    assign o_valid = (r_cnt != '0);
    assign pop     = o_valid && i_ready;
    assign o_free  = (r_cnt == '0) || ((r_cnt == FRAME_CNT_W'(1)) && i_ready);
    assign o_res   = r_buf[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load && o_free) begin
            r_cnt <= i_cnt;
        end else if (pop) begin
            r_cnt <= r_cnt - FRAME_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_free) begin
            r_buf <= i_ents;
        end else if (pop) begin
            for (int k = 0; k < FRAME_LEN - 1; k++) begin
                r_buf[k] <= r_buf[k + 1];
            end
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= FRAME_CNT_W'(FRAME_LEN))
        else $error("result buffer count out of range");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_free)
        else $error("load while results still pending");

    a_pop_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !i_load) |=> (r_cnt == $past(r_cnt) - FRAME_CNT_W'(1)))
        else $error("pop did not retire one beat");

    a_tx_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.kind == KIND_TX && o_res.last) |-> (r_cnt == FRAME_CNT_W'(1)))
        else $error("frame end beat not at buffer tail");

endmodule

/* hw/rtl/modbus_rtu_read_input_master.sv */
// Modbus RTU master for function 0x04 (read input registers). Each input beat
// on s_axis is a start request, one received line byte, or a time tick, chosen
// by s_axis_tuser. A start emits the 8-byte request frame on m_axis as eight
// transmit beats (address, 0x04, start hi/lo, count hi/lo, CRC-16 lo/hi, CRC
// seeded with 0xFFFF, reflected poly 0xA001); a count above MAX_REGISTERS is
// clamped. The block then expects 5 + 2*count response bytes: payload bytes
// (index 3 up to the CRC) are forwarded as they arrive, and the exchange closes
// with one status beat (ok, short response on timeout, or CRC mismatch).
// Response address and function code are not checked. Bytes and ticks seen
// while idle are dropped; a start while waiting abandons the old exchange with
// no status. Timing: one input beat per clock while the result shifter can
// take a load. Every beat passes an input register and one pass of logic into
// an 8-entry result shifter; a start fills it with eight transmit beats, so a
// new beat enters once the shifter reaches its final beat. Byte and tick beats
// give at most one result and sustain one beat per cycle with m_axis_tready
// high. The user writes response_timeout_ticks (reset value 1000) through
// i_cfg_wr_en only while no exchange is in flight; the block does not enforce it.
module modbus_rtu_read_input_master #(
    parameter int MAX_REGISTERS = mrim_pkg::MAX_REGISTERS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config: response_timeout_ticks
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    // request / line side
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] slave_address, [23:8] start_register, [30:24] register_count,
    // [38:31] rx_byte, [39] zero
    input  logic [39:0] s_axis_tdata,
    // [1:0] operation
    input  logic [1:0]  s_axis_tuser,
    // result side
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] data_byte, [9:8] status, [15:10] zero
    output logic [15:0] m_axis_tdata,
    // [1:0] kind
    output logic [1:0]  m_axis_tuser,
    output logic        m_axis_tlast
);
    import mrim_pkg::*;

    logic [15:0] r_timeout;
    logic        r_in_valid;
    t_item       r_in;

    logic        ser_free;
    logic        move;
    logic        in_acc;
    logic [15:0] crc_front;

    logic [6:0]  count_sat;
    t_result [FRAME_LEN-1:0] frame;
    logic        res_valid;
    t_result     res;

    t_result [FRAME_LEN-1:0] ents;
    logic [FRAME_CNT_W-1:0]  ents_cnt;
    t_result     out_res;

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
        end else if (i_cfg_wr_en) begin
            r_timeout <= i_cfg_wr_data;
        end
    end

    // input register; it drains whenever the result shifter can take a load
    assign move          = r_in_valid && ser_free;
    assign s_axis_tready = !r_in_valid || ser_free;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // first three request bytes folded into the CRC before the register
    assign crc_front = crc_byte(crc_byte(crc_byte(CRC_INIT, s_axis_tdata[7:0]),
                                         FUNC_READ_INPUT), s_axis_tdata[23:16]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_acc) begin
            r_in_valid <= 1'b1;
        end else if (move) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in.op        <= t_op'(s_axis_tuser);
            r_in.addr      <= s_axis_tdata[7:0];
            r_in.start_reg <= s_axis_tdata[23:8];
            r_in.count     <= s_axis_tdata[30:24];
            r_in.rx        <= s_axis_tdata[38:31];
            r_in.crc_part  <= crc_front;
        end
    end

    mrim_req_build #(
        .MAX_REGISTERS (MAX_REGISTERS)
    ) u_req_build (
        .i_item      (r_in),
        .o_count_sat (count_sat),
        .o_frame     (frame)
    );

    mrim_resp u_resp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_timeout   (r_timeout),
        .i_go        (move),
        .i_item      (r_in),
        .i_count_sat (count_sat),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // start loads the full frame, other beats at most one result
    always_comb begin
        ents     = frame;
        ents_cnt = '0;
        if (r_in.op == OP_START) begin
            ents_cnt = FRAME_CNT_W'(FRAME_LEN);
        end else if (res_valid) begin
            ents[0]  = res;
            ents_cnt = FRAME_CNT_W'(1);
        end
    end

    mrim_out_ser u_out_ser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (move),
        .i_cnt   (ents_cnt),
        .i_ents  (ents),
        .o_free  (ser_free),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (out_res)
    );

    assign m_axis_tdata = {6'b0, out_res.status, out_res.data};
    assign m_axis_tuser = out_res.kind;
    assign m_axis_tlast = out_res.last;

endmodule
